>>> design/cbm_pkg.sv
// Shared types, codes and constants for the cartridge bank mapper.
// No dependencies; every other design file but cbm_if refers to it by scoped name.
package cbm_pkg;

  typedef enum logic [1:0] {
    CMD_BUS_WRITE = 2'd0,
    CMD_LOW_WRITE = 2'd1,
    CMD_LOW_READ  = 2'd2,
    CMD_TICK      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_PRG    = 2'd1,
    KIND_CHR    = 2'd2,
    KIND_MIRROR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    IRQ_LEAVE  = 2'd0,
    IRQ_ACK    = 2'd1,
    IRQ_ASSERT = 2'd2
  } irq_e;

  typedef enum logic {
    CFG_PRG_SIZE = 1'b0,
    CFG_CHR_SIZE = 1'b1
  } cfg_e;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned BankW    = 10;
  localparam int unsigned DivW     = 11;
  localparam int unsigned SlotW    = 3;
  localparam int unsigned RunW     = 3;

  localparam logic [15:0] OuterAddrA = 16'hB000;
  localparam logic [15:0] OuterAddrB = 16'hB0FF;
  localparam logic [15:0] OuterAddrC = 16'hB100;
  localparam logic [15:0] IgnoreBase = 16'h9000;
  localparam logic [15:0] ShadowBase = 16'h5100;
  localparam logic [7:0]  ReadIdle   = 8'hFF;
  localparam logic [7:0]  PrgSizeRst = 8'd16;
  localparam logic [7:0]  ChrSizeRst = 8'd32;

  // controller -> datapath
  typedef struct packed {
    logic            accept;
    logic            start;
    logic            capture;
    logic [RunW-1:0] idx;
  } cbm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [RunW-1:0] count;
    logic            div_done;
  } cbm_sts_t;

endpackage

>>> design/cbm_if.sv
// Request and result channel interfaces: valid/ready handshake plus payload.
// Depends on nothing but the field widths of the mapper.
interface cbm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] address;
  logic [7:0]  data;
  logic [15:0] tick_cycles;

  modport source (output valid, cmd, address, data, tick_cycles, input ready);
  modport sink   (input valid, cmd, address, data, tick_cycles, output ready);
endinterface

interface cbm_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] slot;
  logic [9:0] bank;
  logic [1:0] mirror_mode;
  logic [7:0] read_data;
  logic [1:0] irq_action;
  logic       last;

  modport source (output valid, kind, slot, bank, mirror_mode, read_data, irq_action, last,
                  input ready);
  modport sink   (input valid, kind, slot, bank, mirror_mode, read_data, irq_action, last,
                  output ready);
endinterface

>>> design/cbm_div.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on cbm_pkg for widths.
module cbm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [cbm_pkg::BankW-1:0] dividend_i,
  input  logic [cbm_pkg::DivW-1:0]  divisor_i,
  output logic                      done_o,
  output logic [cbm_pkg::BankW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(cbm_pkg::BankW + 1);

  logic [cbm_pkg::BankW-1:0] quo_q;
  logic [cbm_pkg::DivW-1:0]  rem_q, rem_d, divisor_q;
  logic [cbm_pkg::DivW:0]    trial, diff;
  logic [CntW-1:0]           cnt_q;
  logic                      done_q;

  // a zero divisor leaves the dividend unreduced
  assign trial = {rem_q, quo_q[cbm_pkg::BankW-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign rem_d = (trial >= {1'b0, divisor_q}) ? diff[cbm_pkg::DivW-1:0]
                                              : trial[cbm_pkg::DivW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntW'(cbm_pkg::BankW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CntW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q     <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[cbm_pkg::BankW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[cbm_pkg::BankW-1:0];

endmodule

>>> design/cbm_dp.sv
// Mapper datapath: register file, write decode, IRQ counter, event selection
// and result registers. Depends on cbm_pkg and cbm_div.
module cbm_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cbm_pkg::cbm_cmd_t            cmd_i,
  output cbm_pkg::cbm_sts_t            sts_o,
  input  logic [1:0]                   req_cmd_i,
  input  logic [15:0]                  req_address_i,
  input  logic [7:0]                   req_data_i,
  input  logic [15:0]                  req_tick_cycles_i,
  input  logic                         cfg_we_i,
  input  logic [cbm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cbm_pkg::CfgDataW-1:0] cfg_data_i,
  output logic [1:0]                   kind_o,
  output logic [2:0]                   slot_o,
  output logic [9:0]                   bank_o,
  output logic [1:0]                   mirror_mode_o,
  output logic [7:0]                   read_data_o,
  output logic [1:0]                   irq_action_o,
  output logic                         last_o
);

  // configuration and mapper state
  logic [7:0]  prg_size_q, chr_size_q;
  logic [7:0]  ctrl_q, ctrl_d, outer_q, outer_d, shadow_q, shadow_d;
  logic [4:0]  m1_q [4];
  logic [4:0]  m1_d [4];
  logic [15:0] irq_cnt_q, irq_cnt_d;
  logic        armed_q, armed_d;

  // run descriptor of the accepted request
  logic [cbm_pkg::RunW-1:0]  nprg_q, nprg_d, count_q, count_d;
  logic                      mir_q, mir_d, chr_q, chr_d;
  logic [7:0]                data_q, rd_q, rd_d;
  logic [cbm_pkg::SlotW-1:0] slot_q;
  cbm_pkg::irq_e             irq_q, irq_d;

  logic [9:0]  off;
  logic        refresh;
  logic [16:0] up_sum;

  // event selected by the run index
  logic [cbm_pkg::RunW-1:0]  k;
  cbm_pkg::kind_e            ev_kind;
  logic [cbm_pkg::SlotW-1:0] ev_slot;
  logic [cbm_pkg::BankW-1:0] ev_raw;
  logic [cbm_pkg::DivW-1:0]  ev_div;
  logic [1:0]                ev_mir;
  logic [5:0]                inner, fixed;

  logic                      div_done;
  logic [cbm_pkg::BankW-1:0] div_rem;

  // result registers
  cbm_pkg::kind_e            kind_q;
  logic [cbm_pkg::SlotW-1:0] oslot_q;
  logic [cbm_pkg::BankW-1:0] bank_q;
  logic [1:0]                omir_q;
  logic [7:0]                ord_q;
  cbm_pkg::irq_e             oirq_q;
  logic                      last_q;

  assign off    = req_address_i[9:0];
  assign up_sum = {1'b0, irq_cnt_q} + {1'b0, req_tick_cycles_i};

  always_comb begin
    ctrl_d    = ctrl_q;
    outer_d   = outer_q;
    shadow_d  = shadow_q;
    m1_d      = m1_q;
    irq_cnt_d = irq_cnt_q;
    armed_d   = armed_q;
    refresh   = 1'b0;
    mir_d     = 1'b0;
    chr_d     = 1'b0;
    rd_d      = 8'h00;
    irq_d     = cbm_pkg::IRQ_LEAVE;
    unique case (req_cmd_i)
      cbm_pkg::CMD_BUS_WRITE: begin
        if (req_address_i == cbm_pkg::OuterAddrA || req_address_i == cbm_pkg::OuterAddrB ||
            req_address_i == cbm_pkg::OuterAddrC) begin
          outer_d = req_data_i;
          refresh = 1'b1;
        end else if (req_address_i < cbm_pkg::IgnoreBase) begin
          case (off[9:8])
            2'd0: begin
              outer_d = req_data_i;
              refresh = 1'b1;
            end
            2'd1: begin
              ctrl_d  = req_data_i;
              refresh = ctrl_q[4] ^ req_data_i[4];
              mir_d   = |(ctrl_q[1:0] ^ req_data_i[1:0]);
            end
            2'd2: begin
              if (!req_address_i[0]) begin
                irq_cnt_d = {irq_cnt_q[15:8], req_data_i};
              end else begin
                irq_cnt_d = {req_data_i, irq_cnt_q[7:0]};
                armed_d   = ctrl_q[7];
              end
              irq_d = cbm_pkg::IRQ_ACK;
            end
            default: begin
              if (!off[4]) begin
                m1_d[req_address_i[1:0]] = req_data_i[4:0];
                refresh                  = ctrl_q[4];
              end else if (!off[3]) begin
                chr_d = (chr_size_q != 8'd0);
              end
            end
          endcase
        end
      end
      cbm_pkg::CMD_LOW_WRITE: begin
        if (req_address_i >= cbm_pkg::ShadowBase) shadow_d = req_data_i;
      end
      cbm_pkg::CMD_LOW_READ: begin
        rd_d = (req_address_i >= cbm_pkg::ShadowBase) ? shadow_q : cbm_pkg::ReadIdle;
      end
      default: begin
        if (armed_q && irq_cnt_q != 16'd0) begin
          if (ctrl_q[6]) begin
            if (req_tick_cycles_i >= irq_cnt_q) begin
              irq_cnt_d = '0;
              armed_d   = 1'b0;
              irq_d     = cbm_pkg::IRQ_ASSERT;
            end else begin
              irq_cnt_d = irq_cnt_q - req_tick_cycles_i;
            end
          end else if (up_sum[16]) begin
            irq_cnt_d = '0;
            armed_d   = 1'b0;
            irq_d     = cbm_pkg::IRQ_ASSERT;
          end else begin
            irq_cnt_d = up_sum[15:0];
          end
        end
      end
    endcase
    nprg_d  = refresh ? (ctrl_d[4] ? 3'd3 : 3'd4) : 3'd0;
    count_d = nprg_d + {2'b00, mir_d} + {2'b00, chr_d};
    if (count_d == '0) count_d = 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_size_q <= cbm_pkg::PrgSizeRst;
      chr_size_q <= cbm_pkg::ChrSizeRst;
      ctrl_q     <= '0;
      outer_q    <= '0;
      shadow_q   <= '0;
      m1_q       <= '{default: '0};
      irq_cnt_q  <= '0;
      armed_q    <= 1'b0;
      nprg_q     <= '0;
      count_q    <= 3'd1;
      mir_q      <= 1'b0;
      chr_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cbm_pkg::CFG_PRG_SIZE: prg_size_q <= cfg_data_i;
          cbm_pkg::CFG_CHR_SIZE: chr_size_q <= cfg_data_i;
        endcase
      end
      if (cmd_i.accept) begin
        ctrl_q    <= ctrl_d;
        outer_q   <= outer_d;
        shadow_q  <= shadow_d;
        m1_q      <= m1_d;
        irq_cnt_q <= irq_cnt_d;
        armed_q   <= armed_d;
        nprg_q    <= nprg_d;
        count_q   <= count_d;
        mir_q     <= mir_d;
        chr_q     <= chr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      data_q <= req_data_i;
      slot_q <= req_address_i[2:0];
      rd_q   <= rd_d;
      irq_q  <= irq_d;
    end
  end

  // pick the event for the current run index from the settled state
  assign k     = cmd_i.idx;
  assign inner = outer_q[5:0];
  assign fixed = {outer_q[5:4], 4'hF};

  always_comb begin
    ev_kind = cbm_pkg::KIND_NONE;
    ev_slot = '0;
    ev_raw  = '0;
    ev_div  = '0;
    ev_mir  = 2'b00;
    if (k < nprg_q) begin
      ev_kind = cbm_pkg::KIND_PRG;
      ev_slot = k;
      ev_div  = {2'b00, prg_size_q, 1'b0};
      if (ctrl_q[4]) ev_raw = {5'b00000, m1_q[k[1:0]]};
      else           ev_raw = {3'b000, (k[1] ? fixed : inner), k[0]};
    end else if (mir_q) begin
      ev_kind = cbm_pkg::KIND_MIRROR;
      ev_mir  = data_q[1:0];
    end else if (chr_q) begin
      ev_kind = cbm_pkg::KIND_CHR;
      ev_slot = slot_q;
      ev_raw  = {outer_q[5:4], data_q};
      ev_div  = {chr_size_q, 3'b000};
    end
  end

  cbm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start),
    .dividend_i (ev_raw),
    .divisor_i  (ev_div),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= ev_kind;
      oslot_q <= ev_slot;
      bank_q  <= div_rem;
      omir_q  <= ev_mir;
      ord_q   <= rd_q;
      oirq_q  <= irq_q;
      last_q  <= (k == count_q - 1'b1);
    end
  end

  assign sts_o.count    = count_q;
  assign sts_o.div_done = div_done;

  assign kind_o        = kind_q;
  assign slot_o        = oslot_q;
  assign bank_o        = bank_q;
  assign mirror_mode_o = omir_q;
  assign read_data_o   = ord_q;
  assign irq_action_o  = oirq_q;
  assign last_o        = last_q;

endmodule

>>> design/cbm_ctrl.sv
// Sequencer: takes one request, steps through its run of results and
// hands each to the result channel. Depends on cbm_pkg.
module cbm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  cbm_pkg::cbm_sts_t sts_i,
  output cbm_pkg::cbm_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVIDE,
    ST_SEND
  } state_e;

  state_e                   state_q;
  logic [cbm_pkg::RunW-1:0] idx_q;
  logic                     valid_q;

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = valid_q;
  assign cmd_o.accept  = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.start   = (state_q == ST_LOAD);
  assign cmd_o.capture = (state_q == ST_DIVIDE) && sts_i.div_done;
  assign cmd_o.idx     = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            idx_q   <= '0;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: state_q <= ST_DIVIDE;
        ST_DIVIDE: begin
          if (sts_i.div_done) begin
            valid_q <= 1'b1;
            state_q <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (out_ready_i) begin
            valid_q <= 1'b0;
            if (idx_q == sts_i.count - 1'b1) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= ST_LOAD;
            end
          end
        end
      endcase
    end
  end

endmodule

>>> design/cartridge_bank_mapper_with_irq.sv
// A request is taken only in idle. Each result of its run passes through a load state,
// the 10-step serial remainder unit and a capture when the unit is done, and is then
// offered on the result channel until it is taken; a request produces 1 to 5 results.
// The next result of the run starts only after the previous one is taken, and the next
// request is taken only after the last result of the run, once the block is idle again.
// Reset (rst_ni, async, active low): mapper state cleared, sizes 16 and 32, idle.
module cartridge_bank_mapper_with_irq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cbm_req_if.sink                      req_i,
  cbm_res_if.source                    res_o,
  input  logic                         cfg_we_i,
  input  logic [cbm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cbm_pkg::CfgDataW-1:0] cfg_data_i
);

  cbm_pkg::cbm_cmd_t cmd;
  cbm_pkg::cbm_sts_t sts;

  // Sequencer: holds the request side off while a run is in flight and
  // advances the run index each time a result request is taken.
  cbm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: decode the request, update mapper state in the accept cycle,
  // then reduce each bank number through the shared remainder unit and
  // drop the result into the output registers.
  cbm_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .req_cmd_i         (req_i.cmd),
    .req_address_i     (req_i.address),
    .req_data_i        (req_i.data),
    .req_tick_cycles_i (req_i.tick_cycles),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .kind_o            (res_o.kind),
    .slot_o            (res_o.slot),
    .bank_o            (res_o.bank),
    .mirror_mode_o     (res_o.mirror_mode),
    .read_data_o       (res_o.read_data),
    .irq_action_o      (res_o.irq_action),
    .last_o            (res_o.last)
  );

  // a new request is never taken while a result is on offer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ready && res_o.valid))
    else $error("request taken while a result is pending");

  // an empty run and a mirroring change always close their run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.kind == cbm_pkg::KIND_NONE || res_o.kind == cbm_pkg::KIND_MIRROR)
      |-> res_o.last)
    else $error("no-change or mirroring result not marked last");

  // the result does not appear in the cycle after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !res_o.valid)
    else $error("result offered too early after a request");

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for cartridge_bank_mapper_with_irq: a directed table, then
// random CPU traffic. Needs cbm_pkg, the cbm_req_if / cbm_res_if interfaces and the
// mapper RTL; a bank-mapping predictor in this file works out every result but those of typed rows.
module tb;
  import cbm_pkg::*;

  // Run length guard: every request making five results, each held up by the receiver.
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned TailCycles = 40;
  localparam int unsigned LongHold = 400;      // receiver hold-off that backs up the requests
  localparam int unsigned PhaseRequests = 70;
  localparam int unsigned MaxReports = 100;

  // One bank-load event as seen on the result channel.
  typedef struct packed {
    kind_e      kind;
    logic [2:0] slot;
    logic [9:0] bank;
    logic [1:0] mirror;
    logic [7:0] rd;
    irq_e       irq;
    logic       last;
  } map_evt_t;

  // One CPU access; typed rows carry the single result that is expected of them.
  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [15:0] cycles;
    logic        typed;
    kind_e       kind;
    logic [7:0]  rd;
    irq_e        irq;
  } cpu_access_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  cbm_req_if req_if ();
  cbm_res_if res_if ();

  cartridge_bank_mapper_with_irq u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Mapper predictor state: sizes, control, outer bank, mode-1 banks, shadow and
  // the IRQ counter, kept exactly as the block should hold them.
  // ---------------------------------------------------------------------------
  logic [7:0]  prg_units;
  logic [7:0]  chr_units;
  logic [7:0]  ctrl_q;
  logic [7:0]  outer_q;
  logic [7:0]  shadow_q;
  logic [4:0]  m1_bank [4];
  logic [15:0] irq_cnt;
  logic        irq_armed;

  map_evt_t    bank_run[$];        // events of the request being predicted
  map_evt_t    pending_events[$];  // results still owed by the block, oldest first
  cpu_access_t cpu_accesses[$];    // requests not yet offered
  cpu_access_t on_bus;             // request currently on the request channel

  logic        req_fire = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned mismatch_cnt = 0;

  // Sender and receiver pacing
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned epoch_left = 0;
  int unsigned stall_bit = 0;
  logic [15:0] stall_mask = '1;
  logic        long_hold_go = 1'b0;
  logic        hold_done = 1'b0;

  cpu_access_t directed_rows [24];

  // Append one event to the run; the run never exceeds five events.
  task automatic add_evt(kind_e kind, logic [2:0] slot, logic [9:0] bank, logic [1:0] mirror);
    map_evt_t e;
    if (bank_run.size() < 5) begin
      e = '0;
      e.kind = kind;
      e.slot = slot;
      e.bank = bank;
      e.mirror = mirror;
      bank_run.push_back(e);
    end
  endtask

  // PRG 8KB bank, wrapped to twice the 16KB count; a zero size leaves it as it is.
  task automatic load_prg(logic [2:0] slot, int unsigned bank);
    int unsigned cnt;
    cnt = 32'(prg_units) * 2;
    if (cnt != 0) bank = bank % cnt;
    add_evt(KIND_PRG, slot, bank[9:0], 2'd0);
  endtask

  task automatic refresh_prg();
    int unsigned inner;
    int unsigned fixed_bank;
    if (ctrl_q[4]) begin
      // mode 1: three switchable slots, the top slot keeps its mapping
      for (int s = 0; s < 3; s++) load_prg(3'(s), 32'(m1_bank[s]));
    end else begin
      inner = 32'(outer_q & 8'h3F);
      fixed_bank = 32'((outer_q & 8'h30) | 8'h0F);
      load_prg(3'd0, inner * 2);
      load_prg(3'd1, inner * 2 + 1);
      load_prg(3'd2, fixed_bank * 2);
      load_prg(3'd3, fixed_bank * 2 + 1);
    end
  endtask

  // CHR 1KB bank with the outer bits on top; no event at all when CHR is absent.
  task automatic load_chr(logic [2:0] slot, logic [7:0] data);
    int unsigned cnt;
    int unsigned bank;
    cnt = 32'(chr_units) * 8;
    if (cnt != 0) begin
      bank = ((32'(outer_q) << 4) & 32'h300) | 32'(data);
      bank = bank % cnt;
      add_evt(KIND_CHR, slot, bank[9:0], 2'd0);
    end
  endtask

  task automatic bus_write(logic [15:0] addr, logic [7:0] data, output irq_e irq);
    logic [9:0] off;
    logic [7:0] diff;
    irq = IRQ_LEAVE;
    off = addr[9:0];
    if (addr == OuterAddrA || addr == OuterAddrB || addr == OuterAddrC) begin
      outer_q = data;
      refresh_prg();
    end else if (addr < IgnoreBase) begin
      case (off[9:8])
        2'd0: begin
          outer_q = data;
          refresh_prg();
        end
        2'd1: begin
          diff = ctrl_q ^ data;
          ctrl_q = data;
          if (diff[4]) refresh_prg();
          if (diff[1:0] != 2'd0) add_evt(KIND_MIRROR, 3'd0, 10'd0, data[1:0]);
        end
        2'd2: begin
          if (!addr[0]) begin
            irq_cnt[7:0] = data;
          end else begin
            irq_cnt[15:8] = data;
            irq_armed = ctrl_q[7];
          end
          irq = IRQ_ACK;
        end
        default: begin
          if (!off[4]) begin
            m1_bank[addr[1:0]] = data[4:0];
            if (ctrl_q[4]) refresh_prg();
          end else if (!off[3]) begin
            load_chr(addr[2:0], data);
          end
        end
      endcase
    end
  endtask

  task automatic advance_irq_counter(logic [15:0] cyc, output irq_e irq);
    logic [16:0] sum;
    irq = IRQ_LEAVE;
    if (irq_armed && irq_cnt != 16'd0) begin
      if (ctrl_q[6]) begin
        if (cyc >= irq_cnt) begin
          irq_cnt = 16'd0;
          irq_armed = 1'b0;
          irq = IRQ_ASSERT;
        end else begin
          irq_cnt = irq_cnt - cyc;
        end
      end else begin
        sum = {1'b0, irq_cnt} + {1'b0, cyc};
        if (sum[16]) begin
          irq_cnt = 16'd0;
          irq_armed = 1'b0;
          irq = IRQ_ASSERT;
        end else begin
          irq_cnt = sum[15:0];
        end
      end
    end
  endtask

  // Advance the predictor by one accepted request and queue the results it owes.
  task automatic map_request(cpu_access_t a);
    irq_e       irq;
    logic [7:0] rd;
    map_evt_t   e;
    bank_run.delete();
    irq = IRQ_LEAVE;
    rd = 8'h00;
    case (a.cmd)
      CMD_BUS_WRITE: bus_write(a.addr, a.data, irq);
      CMD_LOW_WRITE: if (a.addr >= ShadowBase) shadow_q = a.data;
      CMD_LOW_READ:  rd = (a.addr >= ShadowBase) ? shadow_q : ReadIdle;
      default:       advance_irq_counter(a.cycles, irq);
    endcase
    if (bank_run.size() == 0) add_evt(KIND_NONE, 3'd0, 10'd0, 2'd0);
    if (a.typed) begin
      // table row: the expectation is written out by hand, the state still advances
      e = '0;
      e.kind = a.kind;
      e.rd = a.rd;
      e.irq = a.irq;
      e.last = 1'b1;
      pending_events.push_back(e);
    end else begin
      for (int k = 0; k < bank_run.size(); k++) begin
        e = bank_run[k];
        e.rd = rd;
        e.irq = irq;
        e.last = (k == bank_run.size() - 1);
        pending_events.push_back(e);
      end
    end
  endtask

  task automatic flag_mismatch(string what, map_evt_t got, map_evt_t want);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReports)
      $display("%0t mismatch (%s): got k%0d s%0d b%0d m%0d rd%02h irq%0d l%0d,",
               $time, what, got.kind, got.slot, got.bank, got.mirror, got.rd, got.irq,
               got.last,
               " want k%0d s%0d b%0d m%0d rd%02h irq%0d l%0d",
               want.kind, want.slot, want.bank, want.mirror, want.rd, want.irq, want.last);
  endtask

  task automatic check_result(map_evt_t got);
    map_evt_t want;
    string    bad;
    bad = "";
    if (pending_events.size() == 0) begin
      flag_mismatch("result with nothing pending", got, got);
    end else begin
      want = pending_events.pop_front();
      if (got.kind != want.kind) bad = {bad, " kind"};
      if (got.slot != want.slot) bad = {bad, " slot"};
      if (got.bank != want.bank) bad = {bad, " bank"};
      if (got.mirror != want.mirror) bad = {bad, " mirror"};
      if (got.rd != want.rd) bad = {bad, " read_data"};
      if (got.irq != want.irq) bad = {bad, " irq"};
      if (got.last != want.last) bad = {bad, " last"};
      if (bad != "") flag_mismatch({"field", bad}, got, want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Rising edge: count cycles, take results, then note any request accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : sample_edge
    map_evt_t got;
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb failed");
      $finish;
    end else begin
      req_fire = req_if.valid && req_if.ready;
      if (res_if.valid && res_if.ready) begin
        got.kind = kind_e'(res_if.kind);
        got.slot = res_if.slot;
        got.bank = res_if.bank;
        got.mirror = res_if.mirror_mode;
        got.rd = res_if.read_data;
        got.irq = irq_e'(res_if.irq_action);
        got.last = res_if.last;
        check_result(got);
      end
      if (req_fire) map_request(on_bus);
    end
  end

  // Sender: bursts of requests with random gaps; hold each request until it is taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!req_if.valid || req_fire)) begin
      if (gap_left != 0 || cpu_accesses.size() == 0) begin
        req_if.valid = 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        on_bus = cpu_accesses.pop_front();
        req_if.cmd = on_bus.cmd;
        req_if.address = on_bus.addr;
        req_if.data = on_bus.data;
        req_if.tick_cycles = on_bus.cycles;
        req_if.valid = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // a quarter of the bursts run straight into the next one
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
  end

  // Receiver: a random 16-bit ready mask, redrawn at the start of each epoch and sometimes all ready,
  // and once a long hold-off so that the block backs up into its request side.
  always @(negedge clk_i) begin
    if (long_hold_go && !hold_done) begin
      hold_left = LongHold;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_if.ready = 1'b0;
    end else begin
      if (epoch_left == 0) begin
        epoch_left = 64;
        stall_mask = 16'($urandom);
        if ($urandom_range(0, 3) == 0) stall_mask = '1;
      end
      epoch_left--;
      res_if.ready = stall_mask[stall_bit];
      stall_bit = (stall_bit + 1) % 16;
    end
  end

  // Random bus address inside the decode window (below 9000) with the offset forced.
  function automatic logic [15:0] decode_addr(logic [1:0] region, logic [7:0] low);
    logic [15:0] a;
    a = 16'($urandom_range(0, 16'h8FFF));
    a[9:8] = region;
    a[7:0] = low;
    return a;
  endfunction

  task automatic queue_access(cmd_e cmd, logic [15:0] addr, logic [7:0] data,
                              logic [15:0] cycles);
    cpu_access_t a;
    a = '0;
    a.cmd = cmd;
    a.addr = addr;
    a.data = data;
    a.cycles = cycles;
    cpu_accesses.push_back(a);
  endtask

  // Random traffic: mostly meaningful register writes and complete IRQ programming
  // sequences (control, low byte, high byte, then ticks), with reads, shadow writes,
  // stray ticks and ignored writes mixed in. Ignored requests are not counted.
  task automatic queue_random_accesses(int unsigned n);
    int unsigned queued;
    int unsigned ticks;
    logic [15:0] a;
    logic [7:0]  d;
    logic [7:0]  hb;
    logic [15:0] cyc;
    queued = 0;
    while (queued < n) begin
      d = 8'($urandom);
      cyc = 16'($urandom);
      case ($urandom_range(0, 15))
        0, 1: begin
          case ($urandom_range(0, 5))
            0:       a = OuterAddrA;
            1:       a = OuterAddrB;
            2:       a = OuterAddrC;
            default: a = decode_addr(2'd0, 8'($urandom));
          endcase
          queue_access(CMD_BUS_WRITE, a, d, cyc);
          queued++;
        end
        2, 3: begin
          queue_access(CMD_BUS_WRITE, decode_addr(2'd1, 8'($urandom)), d, cyc);
          queued++;
        end
        4, 5: begin
          a = decode_addr(2'd3, 8'($urandom) & 8'hEF);
          queue_access(CMD_BUS_WRITE, a, d, cyc);
          queued++;
        end
        6, 7: begin
          a = decode_addr(2'd3, (8'($urandom) & 8'hE7) | 8'h10);
          queue_access(CMD_BUS_WRITE, a, d, cyc);
          queued++;
        end
        8: begin
          // dead corner of the window or above it
          if ($urandom_range(0, 1) == 0) a = decode_addr(2'd3, 8'($urandom) | 8'h18);
          else a = 16'($urandom_range(IgnoreBase, 16'hFFFF));
          queue_access(CMD_BUS_WRITE, a, d, cyc);
        end
        9: begin
          a = 16'($urandom);
          queue_access(CMD_LOW_WRITE, a, d, cyc);
          if (a >= ShadowBase) queued++;
        end
        10: begin
          queue_access(CMD_LOW_READ, 16'($urandom), d, cyc);
          queued++;
        end
        11: begin
          queue_access(CMD_TICK, 16'($urandom), d, cyc);
          queued++;
        end
        default: begin
          // arm the counter most of the time, direction at random
          d[7] = ($urandom_range(0, 7) != 0);
          queue_access(CMD_BUS_WRITE, decode_addr(2'd1, 8'($urandom)), d, cyc);
          if ($urandom_range(0, 7) == 0) hb = 8'($urandom);
          else if (d[6]) hb = 8'($urandom_range(0, 1));
          else hb = 8'($urandom_range(8'hFE, 8'hFF));
          a = decode_addr(2'd2, 8'($urandom) & 8'hFE);
          if ($urandom_range(0, 15) == 0) begin
            queue_access(CMD_BUS_WRITE, a, 8'h00, 16'($urandom));
            hb = 8'h00;
          end else begin
            queue_access(CMD_BUS_WRITE, a, 8'($urandom), 16'($urandom));
          end
          queue_access(CMD_BUS_WRITE, decode_addr(2'd2, 8'($urandom) | 8'h01), hb,
                       16'($urandom));
          ticks = $urandom_range(2, 6);
          for (int t = 0; t < ticks; t++) begin
            if ($urandom_range(0, 7) == 0) cyc = 16'($urandom);
            else cyc = 16'($urandom_range(0, 200));
            queue_access(CMD_TICK, 16'($urandom), 8'($urandom), cyc);
          end
          queued += 3 + ticks;
        end
      endcase
    end
  endtask

  // Block until every request is taken and every result is in, then let it settle.
  task automatic wait_idle();
    while (cpu_accesses.size() != 0 || req_if.valid || pending_events.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_size(cfg_e idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    if (idx == CFG_PRG_SIZE) prg_units = val;
    else chr_units = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  initial begin : main_seq
    logic [7:0] prg_set;
    logic [7:0] chr_set;

    // Hold every input at a known value from time zero.
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.cmd = '0;
    req_if.address = '0;
    req_if.data = '0;
    req_if.tick_cycles = '0;
    res_if.ready = 1'b0;

    prg_units = PrgSizeRst;
    chr_units = ChrSizeRst;
    ctrl_q = 8'h00;
    outer_q = 8'h00;
    shadow_q = 8'h00;
    for (int i = 0; i < 4; i++) m1_bank[i] = 5'd0;
    irq_cnt = 16'd0;
    irq_armed = 1'b0;

    // cmd, address, data, tick cycles, typed, then kind / read data / irq when typed
    directed_rows = '{
      // shadow area straight after reset: empty shadow, idle read, unarmed tick, shadow writes and read-back
      '{CMD_LOW_READ,  16'h5100, 8'hA5, 16'h0000, 1'b1, KIND_NONE, 8'h00, IRQ_LEAVE},
      '{CMD_LOW_READ,  16'h4020, 8'h00, 16'hFFFF, 1'b1, KIND_NONE, 8'hFF, IRQ_LEAVE},
      '{CMD_TICK,      16'h0000, 8'h00, 16'hFFFF, 1'b1, KIND_NONE, 8'h00, IRQ_LEAVE},
      '{CMD_LOW_WRITE, 16'h50FF, 8'hAA, 16'h0000, 1'b1, KIND_NONE, 8'h00, IRQ_LEAVE},
      '{CMD_LOW_WRITE, 16'hFFFF, 8'h55, 16'h0000, 1'b1, KIND_NONE, 8'h00, IRQ_LEAVE},
      '{CMD_LOW_READ,  16'hFFFF, 8'h00, 16'h0000, 1'b1, KIND_NONE, 8'h55, IRQ_LEAVE},
      // outer bank via the window and the fixed addresses, mode 0 refreshes
      '{CMD_BUS_WRITE, 16'h8000, 8'hFF, 16'h0000, 1'b0, KIND_NONE, 8'h00, IRQ_LEAVE},
      '{CMD_BUS_WRITE, 16'hB0FF, 8'h00, 16'h0000, 1'b0, KIND_NONE, 8'h00, IRQ_LEAVE},
      '{CMD_BUS_WRITE, 16'hB100, 8'h3F, 16'h0000, 1'b0, KIND_NONE, 8'h00, IRQ_LEAVE},
      // into mode 1 with mirroring change, arm and count down; then a mode-1 bank and a CHR write
      '{CMD_BUS_WRITE, 16'h8100, 8'hD3, 16'h0000, 1'b0, KIND_NONE, 8'h00, IRQ_LEAVE},
      '{CMD_BUS_WRITE, 16'h8300, 8'hFF, 16'h0000, 1'b0, KIND_NONE, 8'h00, IRQ_LEAVE},
      '{CMD_BUS_WRITE, 16'h8313, 8'h81, 16'h0000, 1'b0, KIND_NONE, 8'h00, IRQ_LEAVE},
      // dead corner and ignored area
      '{CMD_BUS_WRITE, 16'h8318, 8'h12, 16'h0000, 1'b1, KIND_NONE, 8'h00, IRQ_LEAVE},
      '{CMD_BUS_WRITE, 16'h9000, 8'h12, 16'h0000, 1'b1, KIND_NONE, 8'h00, IRQ_LEAVE},
      // counter to 5, count down to zero
      '{CMD_BUS_WRITE, 16'h8200, 8'h05, 16'h0000, 1'b1, KIND_NONE, 8'h00, IRQ_ACK},
      '{CMD_BUS_WRITE, 16'h8201, 8'h00, 16'h0000, 1'b1, KIND_NONE, 8'h00, IRQ_ACK},
      '{CMD_TICK,      16'hFFFF, 8'hFF, 16'h0003, 1'b1, KIND_NONE, 8'h00, IRQ_LEAVE},
      '{CMD_TICK,      16'h0000, 8'h00, 16'h0002, 1'b1, KIND_NONE, 8'h00, IRQ_ASSERT},
      // back to mode 0 with mirroring change: the longest run
      '{CMD_BUS_WRITE, 16'h8100, 8'h80, 16'h0000, 1'b0, KIND_NONE, 8'h00, IRQ_LEAVE},
      // counter to FFFF, count up wraps on a single cycle
      '{CMD_BUS_WRITE, 16'h82FE, 8'hFF, 16'h0000, 1'b1, KIND_NONE, 8'h00, IRQ_ACK},
      '{CMD_BUS_WRITE, 16'h82FF, 8'hFF, 16'h0000, 1'b1, KIND_NONE, 8'h00, IRQ_ACK},
      '{CMD_TICK,      16'h0000, 8'h00, 16'h0001, 1'b1, KIND_NONE, 8'h00, IRQ_ASSERT},
      // address below the cartridge area still decodes; top address is ignored
      '{CMD_BUS_WRITE, 16'h0000, 8'hFF, 16'h0000, 1'b0, KIND_NONE, 8'h00, IRQ_LEAVE},
      '{CMD_BUS_WRITE, 16'hFFFF, 8'h00, 16'h0000, 1'b1, KIND_NONE, 8'h00, IRQ_LEAVE}
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset sizes.
    foreach (directed_rows[i]) cpu_accesses.push_back(directed_rows[i]);
    wait_idle();

    // Random phases, each under its own size setting; extremes first.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          prg_set = 8'd1;
          chr_set = 8'd0;
        end
        1: begin
          prg_set = 8'd255;
          chr_set = 8'd255;
        end
        2: begin
          prg_set = 8'd0;
          chr_set = 8'd1;
        end
        default: begin
          prg_set = 8'($urandom_range(1, 255));
          chr_set = 8'($urandom_range(0, 255));
        end
      endcase
      write_size(CFG_PRG_SIZE, prg_set);
      write_size(CFG_CHR_SIZE, chr_set);
      // starve the result side once while the sender keeps offering
      if (phase == 0) long_hold_go = 1'b1;
      queue_random_accesses(PhaseRequests);
      wait_idle();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (pending_events.size() != 0)
      flag_mismatch("results never arrived", pending_events[0], pending_events[0]);
    if (mismatch_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/cbm_pkg.sv
design/cbm_if.sv
design/cbm_div.sv
design/cbm_dp.sv
design/cbm_ctrl.sv
design/cartridge_bank_mapper_with_irq.sv
dv/tb.sv
